@@ src/pgb_pkg.sv @@
// ----------------------------------------------------------------------------
// pgb_pkg
// Shared types, constants and helpers for the primitive group builder.
// ----------------------------------------------------------------------------
package pgb_pkg;

    localparam int MATERIAL_BITS  = 16;
    localparam int MATERIAL_WIDTH = 16;
    localparam int MAT_KEEP       = (MATERIAL_BITS < MATERIAL_WIDTH) ? MATERIAL_BITS
                                                                     : MATERIAL_WIDTH;

    localparam logic [31:0] WIDE_LIMIT      = 32'd65535;
    localparam logic [31:0] INDICES_PER_TRI = 32'd3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    typedef struct packed {
        logic [31:0] start_index;
        logic [31:0] start_vertex;
        logic [31:0] vertex_span;
        logic [31:0] triangles;
        logic [31:0] group_number;
        logic        final_record;
        logic        wide_indices;
        logic [31:0] largest_index;
        logic [31:0] index_total;
    } t_rec;

    typedef struct packed {
        logic has_closed;
        logic has_final;
        t_rec closed;
        t_rec fin;
    } t_entry;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    typedef enum logic {
        BACK_FIRST,
        BACK_SECOND
    } t_back_state;

    function automatic logic [31:0] umax32(input logic [31:0] x, input logic [31:0] y);
        return (x > y) ? x : y;
    endfunction

    function automatic logic [31:0] umin32(input logic [31:0] x, input logic [31:0] y);
        return (x < y) ? x : y;
    endfunction

endpackage

@@ src/pgb_front.sv @@
// ----------------------------------------------------------------------------
// pgb_front
// Accepts triangles, tracks the open group and builds closed and final records.
// ----------------------------------------------------------------------------
module pgb_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [31:0]            i_vertex_a,
    input  logic [31:0]            i_vertex_b,
    input  logic [31:0]            i_vertex_c,
    input  logic [15:0]            i_material,
    input  logic                   i_last_triangle,
    input  pgb_pkg::t_queue_status i_status,
    output logic                   o_accept,
    output logic                   o_push,
    output pgb_pkg::t_entry        o_entry
);

    logic [pgb_pkg::MAT_KEEP-1:0] r_cur_mat, n_cur_mat;
    logic [31:0] r_start_index, n_start_index;
    logic [31:0] r_start_vertex, n_start_vertex;
    logic [31:0] r_span, n_span;
    logic [31:0] r_count, n_count;
    logic [31:0] r_max_seen, n_max_seen;
    logic [31:0] r_index_pos, n_index_pos;
    logic [31:0] r_groups, n_groups;

    logic [pgb_pkg::MAT_KEEP-1:0] mat_k;
    logic        closing;
    logic [31:0] sv0, span0, cnt0, si0, ge0;
    logic [31:0] tri_max, grp_max, sv1, span1, cnt1, max1, idx1;

    assign o_accept = i_valid && !i_status.full;
    assign mat_k    = i_material[pgb_pkg::MAT_KEEP-1:0];
    assign closing  = (mat_k != r_cur_mat);

    always_comb begin
        sv0     = closing ? i_vertex_a : r_start_vertex;
        span0   = closing ? 32'd0 : r_span;
        cnt0    = closing ? 32'd0 : r_count;
        si0     = closing ? r_index_pos : r_start_index;
        ge0     = r_groups + {31'd0, closing};
        tri_max = pgb_pkg::umax32(i_vertex_a, pgb_pkg::umax32(i_vertex_b, i_vertex_c));
        grp_max = pgb_pkg::umax32(tri_max + 32'd1, sv0 + span0);
        sv1     = pgb_pkg::umin32(pgb_pkg::umin32(i_vertex_a, i_vertex_b),
                                  pgb_pkg::umin32(i_vertex_c, sv0));
        span1   = grp_max - sv1;
        cnt1    = cnt0 + 32'd1;
        max1    = pgb_pkg::umax32(tri_max, r_max_seen);
        idx1    = r_index_pos + pgb_pkg::INDICES_PER_TRI;
    end

    always_comb begin
        o_entry.has_closed          = closing;
        o_entry.has_final           = i_last_triangle;
        o_entry.closed.start_index  = r_start_index;
        o_entry.closed.start_vertex = r_start_vertex;
        o_entry.closed.vertex_span  = r_span;
        o_entry.closed.triangles    = r_count;
        o_entry.closed.group_number = r_groups;
        o_entry.closed.final_record = 1'b0;
        o_entry.closed.wide_indices = 1'b0;
        o_entry.closed.largest_index = 32'd0;
        o_entry.closed.index_total  = 32'd0;
        o_entry.fin.start_index     = si0;
        o_entry.fin.start_vertex    = sv1;
        o_entry.fin.vertex_span     = span1;
        o_entry.fin.triangles       = cnt1;
        o_entry.fin.group_number    = ge0;
        o_entry.fin.final_record    = 1'b1;
        o_entry.fin.wide_indices    = (max1 > pgb_pkg::WIDE_LIMIT);
        o_entry.fin.largest_index   = max1;
        o_entry.fin.index_total     = idx1;
        o_push = o_accept && (closing || i_last_triangle);
    end

    always_comb begin
        n_cur_mat      = r_cur_mat;
        n_start_index  = r_start_index;
        n_start_vertex = r_start_vertex;
        n_span         = r_span;
        n_count        = r_count;
        n_max_seen     = r_max_seen;
        n_index_pos    = r_index_pos;
        n_groups       = r_groups;
        if (o_accept) begin
            if (i_last_triangle) begin
                n_cur_mat      = '0;
                n_start_index  = '0;
                n_start_vertex = '0;
                n_span         = '0;
                n_count        = '0;
                n_max_seen     = '0;
                n_index_pos    = '0;
                n_groups       = '0;
            end else begin
                n_cur_mat      = mat_k;
                n_start_index  = si0;
                n_start_vertex = sv1;
                n_span         = span1;
                n_count        = cnt1;
                n_max_seen     = max1;
                n_index_pos    = idx1;
                n_groups       = ge0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_mat      <= '0;
            r_start_index  <= '0;
            r_start_vertex <= '0;
            r_span         <= '0;
            r_count        <= '0;
            r_max_seen     <= '0;
            r_index_pos    <= '0;
            r_groups       <= '0;
        end else begin
            r_cur_mat      <= n_cur_mat;
            r_start_index  <= n_start_index;
            r_start_vertex <= n_start_vertex;
            r_span         <= n_span;
            r_count        <= n_count;
            r_max_seen     <= n_max_seen;
            r_index_pos    <= n_index_pos;
            r_groups       <= n_groups;
        end
    end

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_accept && i_last_triangle) |=>
            (r_count == 32'd0 && r_max_seen == 32'd0 && r_groups == 32'd0))
        else $error("state not cleared after last triangle");

    a_push_has_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (o_entry.has_closed || o_entry.has_final))
        else $error("pushed entry without record");

endmodule

@@ src/pgb_queue.sv @@
// ----------------------------------------------------------------------------
// pgb_queue
// Short register queue between the front and back parts.
// ----------------------------------------------------------------------------
module pgb_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_push,
    input  pgb_pkg::t_entry        i_entry,
    input  logic                   i_pop,
    output pgb_pkg::t_queue_status o_status,
    output pgb_pkg::t_entry        o_head
);

    localparam logic [pgb_pkg::QUEUE_AW:0] FULL_CNT =
        (pgb_pkg::QUEUE_AW+1)'(pgb_pkg::QUEUE_DEPTH);

    pgb_pkg::t_entry r_mem [pgb_pkg::QUEUE_DEPTH];
    logic [pgb_pkg::QUEUE_AW-1:0] r_wptr, n_wptr;
    logic [pgb_pkg::QUEUE_AW-1:0] r_rptr, n_rptr;
    logic [pgb_pkg::QUEUE_AW:0]   r_count, n_count;

    assign o_status.full  = (r_count == FULL_CNT);
    assign o_status.empty = (r_count == '0);
    assign o_head         = r_mem[r_rptr];

    always_comb begin
        n_wptr  = i_push ? r_wptr + 1'b1 : r_wptr;
        n_rptr  = i_pop  ? r_rptr + 1'b1 : r_rptr;
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_entry;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_status.full || i_pop))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_status.empty)
        else $error("queue underflow");

endmodule

@@ src/pgb_back.sv @@
// ----------------------------------------------------------------------------
// pgb_back
// Sends the one or two records of each queued entry, one item at a time.
// ----------------------------------------------------------------------------
module pgb_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  pgb_pkg::t_queue_status i_status,
    input  pgb_pkg::t_entry        i_head,
    input  logic                   i_stall,
    output logic                   o_pop,
    output logic                   o_valid,
    output pgb_pkg::t_rec          o_rec
);

    pgb_pkg::t_back_state r_state, n_state;
    logic two_recs;
    logic take;

    assign two_recs = i_head.has_closed && i_head.has_final;
    assign o_valid  = !i_status.empty;
    assign take     = o_valid && !i_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            pgb_pkg::BACK_FIRST: begin
                if (take && two_recs) begin
                    n_state = pgb_pkg::BACK_SECOND;
                end
            end
            pgb_pkg::BACK_SECOND: begin
                if (take) begin
                    n_state = pgb_pkg::BACK_FIRST;
                end
            end
            default: n_state = pgb_pkg::BACK_FIRST;
        endcase
    end

    always_comb begin
        case (r_state)
            pgb_pkg::BACK_FIRST: begin
                o_rec = i_head.has_closed ? i_head.closed : i_head.fin;
                o_pop = take && !two_recs;
            end
            pgb_pkg::BACK_SECOND: begin
                o_rec = i_head.fin;
                o_pop = take;
            end
            default: begin
                o_rec = i_head.fin;
                o_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pgb_pkg::BACK_FIRST;
        end else begin
            r_state <= n_state;
        end
    end

    a_second_needs_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pgb_pkg::BACK_SECOND) |-> (o_valid && two_recs))
        else $error("second record without a pair");

endmodule

@@ src/primitive_group_builder.sv @@
// ----------------------------------------------------------------------------
// primitive_group_builder
// Cuts a triangle stream into primitive groups by material.
//
// Input channel: i_valid / o_stall carry one triangle per item (three vertex
// indices, material, last flag). Output channel: o_valid / i_stall carry one
// group record per item. An item moves when valid is high and stall is low.
// A material change closes the open group and yields a record; the triangle
// marked last yields a final record with largest index and index total.
// A triangle's records pass through the queue registers before they are offered.
// Throughput: one triangle per cycle while the queue is not full; a triangle
// with two records offers them one after the other. The front update (compare,
// min/max, one add and one subtract on 32 bits) sets the cycle time.
// A four-entry queue sits between front and back; o_stall rises only when it
// is full, so the front keeps taking triangles while the receiver stalls.
// Reset clears all group state to zero and empties the queue.
// ----------------------------------------------------------------------------
module primitive_group_builder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_vertex_a,
    input  logic [31:0] i_vertex_b,
    input  logic [31:0] i_vertex_c,
    input  logic [15:0] i_material,
    input  logic        i_last_triangle,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_group_start_index,
    output logic [31:0] o_group_start_vertex,
    output logic [31:0] o_group_vertex_span,
    output logic [31:0] o_group_triangles,
    output logic [31:0] o_group_number,
    output logic        o_final_record,
    output logic        o_wide_indices,
    output logic [31:0] o_largest_index,
    output logic [31:0] o_index_total
);

    pgb_pkg::t_queue_status status;
    pgb_pkg::t_entry        push_entry;
    pgb_pkg::t_entry        head;
    pgb_pkg::t_rec          rec;
    logic                   accept;
    logic                   push;
    logic                   pop;

    pgb_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_vertex_a      (i_vertex_a),
        .i_vertex_b      (i_vertex_b),
        .i_vertex_c      (i_vertex_c),
        .i_material      (i_material),
        .i_last_triangle (i_last_triangle),
        .i_status        (status),
        .o_accept        (accept),
        .o_push          (push),
        .o_entry         (push_entry)
    );

    pgb_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_entry  (push_entry),
        .i_pop    (pop),
        .o_status (status),
        .o_head   (head)
    );

    pgb_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .i_head   (head),
        .i_stall  (i_stall),
        .o_pop    (pop),
        .o_valid  (o_valid),
        .o_rec    (rec)
    );

    assign o_stall              = status.full;
    assign o_group_start_index  = rec.start_index;
    assign o_group_start_vertex = rec.start_vertex;
    assign o_group_vertex_span  = rec.vertex_span;
    assign o_group_triangles    = rec.triangles;
    assign o_group_number       = rec.group_number;
    assign o_final_record       = rec.final_record;
    assign o_wide_indices       = rec.wide_indices;
    assign o_largest_index      = rec.largest_index;
    assign o_index_total        = rec.index_total;

    a_stall_blocks_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> (i_valid && !o_stall))
        else $error("triangle taken while stalled");

endmodule

@@ dv/primitive_group_builder_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// primitive_group_builder_test
// Self-checking bench for the primitive group builder. A driver feeds
// triangles from a pending queue and a monitor checks each group record,
// field by field, against a local model of the grouping. The model folds
// every accepted triangle into its own copy of the group state. Stimulus is
// a directed set of corner cases, then random meshes. Both sides idle and
// stall at random in the first two of three phases; the third has no idling.
// ----------------------------------------------------------------------------
module primitive_group_builder_test;

    localparam int CLK_HALF     = 10;
    localparam int TARGET_TRIS  = 1100;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [15:0] mat;
        logic        last;
        logic        hold;
    } t_tri_item;

    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        i_valid         = 1'b0;
    logic        o_stall;
    logic [31:0] i_vertex_a      = '0;
    logic [31:0] i_vertex_b      = '0;
    logic [31:0] i_vertex_c      = '0;
    logic [15:0] i_material      = '0;
    logic        i_last_triangle = 1'b0;
    logic        o_valid;
    logic        i_stall         = 1'b0;
    logic [31:0] o_group_start_index;
    logic [31:0] o_group_start_vertex;
    logic [31:0] o_group_vertex_span;
    logic [31:0] o_group_triangles;
    logic [31:0] o_group_number;
    logic        o_final_record;
    logic        o_wide_indices;
    logic [31:0] o_largest_index;
    logic [31:0] o_index_total;

    primitive_group_builder dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .o_stall              (o_stall),
        .i_vertex_a           (i_vertex_a),
        .i_vertex_b           (i_vertex_b),
        .i_vertex_c           (i_vertex_c),
        .i_material           (i_material),
        .i_last_triangle      (i_last_triangle),
        .o_valid              (o_valid),
        .i_stall              (i_stall),
        .o_group_start_index  (o_group_start_index),
        .o_group_start_vertex (o_group_start_vertex),
        .o_group_vertex_span  (o_group_vertex_span),
        .o_group_triangles    (o_group_triangles),
        .o_group_number       (o_group_number),
        .o_final_record       (o_final_record),
        .o_wide_indices       (o_wide_indices),
        .o_largest_index      (o_largest_index),
        .o_index_total        (o_index_total)
    );

    t_tri_item     pending_tris[$];
    pgb_pkg::t_rec expected_groups[$];

    logic [15:0] cur_material;
    logic [31:0] grp_start_index;
    logic [31:0] grp_start_vertex;
    logic [31:0] grp_span;
    logic [31:0] grp_tri_count;
    logic [31:0] max_index_seen;
    logic [31:0] tri_number;
    logic [31:0] group_count;

    int tris_total;
    int tris_accepted;
    int groups_checked;
    int meshes_closed;
    int mismatches;
    int cycle_count;
    int tx_idle_pct;
    int rx_idle_pct;

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    function automatic logic [31:0] max_u32(logic [31:0] x, logic [31:0] y);
        return (x > y) ? x : y;
    endfunction

    function automatic logic [31:0] min_u32(logic [31:0] x, logic [31:0] y);
        return (x < y) ? x : y;
    endfunction

    function automatic void clear_mesh_state();
        cur_material     = '0;
        grp_start_index  = '0;
        grp_start_vertex = '0;
        grp_span         = '0;
        grp_tri_count    = '0;
        max_index_seen   = '0;
        tri_number       = '0;
        group_count      = '0;
    endfunction

    function automatic void emit_group(logic fin);
        pgb_pkg::t_rec r;
        r.start_index   = grp_start_index;
        r.start_vertex  = grp_start_vertex;
        r.vertex_span   = grp_span;
        r.triangles     = grp_tri_count;
        r.group_number  = group_count;
        r.final_record  = fin;
        r.wide_indices  = fin && (max_index_seen > 32'd65535);
        r.largest_index = fin ? max_index_seen : 32'd0;
        r.index_total   = fin ? tri_number * 32'd3 : 32'd0;
        expected_groups = {expected_groups, r};
        group_count = group_count + 32'd1;
    endfunction

    function automatic void fold_triangle(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                          logic [15:0] mat_in, logic last);
        logic [15:0] mat;
        logic [31:0] tri_max;
        logic [31:0] grp_max;
        mat = mat_in & 16'((32'd1 << pgb_pkg::MAT_KEEP) - 32'd1);
        if (mat != cur_material) begin
            emit_group(1'b0);
            grp_start_index  = tri_number * 32'd3;
            grp_start_vertex = a;
            grp_span         = '0;
            grp_tri_count    = '0;
            cur_material     = mat;
        end
        grp_tri_count    = grp_tri_count + 32'd1;
        tri_max          = max_u32(a, max_u32(b, c));
        grp_max          = max_u32(tri_max + 32'd1, grp_start_vertex + grp_span);
        grp_start_vertex = min_u32(min_u32(a, b), min_u32(c, grp_start_vertex));
        grp_span         = grp_max - grp_start_vertex;
        max_index_seen   = max_u32(tri_max, max_index_seen);
        tri_number       = tri_number + 32'd1;
        if (last) begin
            emit_group(1'b1);
            clear_mesh_state();
            meshes_closed++;
        end
    endfunction

    function automatic void add_tri(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                                    logic [15:0] mat, logic last);
        t_tri_item t;
        t.a    = a;
        t.b    = b;
        t.c    = c;
        t.mat  = mat;
        t.last = last;
        t.hold = 1'b0;
        pending_tris = {pending_tris, t};
        tris_total++;
    endfunction

    function automatic void add_hold();
        t_tri_item t;
        t      = '{default: '0};
        t.hold = 1'b1;
        pending_tris = {pending_tris, t};
    endfunction

    function automatic logic [31:0] pick_vertex(int kind, logic [31:0] base);
        if ($urandom_range(99) < 10) return $urandom;
        case (kind)
            0: return base + $urandom_range(300);
            1: return 32'd65400 + $urandom_range(270);
            2: return $urandom;
            default: return 32'hFFFF_FFFF - $urandom_range(40);
        endcase
    endfunction

    function automatic void add_random_mesh(int len);
        int          kind;
        logic [31:0] base;
        logic [15:0] mats[4];
        logic [15:0] mat;
        kind = $urandom_range(3);
        base = (kind == 0) ? $urandom_range(5000) : $urandom;
        foreach (mats[k]) mats[k] = ($urandom_range(1) == 0) ? 16'($urandom_range(7))
                                                              : 16'($urandom);
        mat = ($urandom_range(2) == 0) ? mats[$urandom_range(3)] : 16'd0;
        for (int n = 0; n < len; n++) begin
            if ($urandom_range(99) < 15) mat = mats[$urandom_range(3)];
            add_tri(pick_vertex(kind, base), pick_vertex(kind, base),
                    pick_vertex(kind, base), mat, n == len - 1);
        end
    endfunction

    function automatic void build_stimulus();
        int len;
        // leading group keeps vertex 0, then a material change
        add_tri(32'd10, 32'd20, 32'd30, 16'd0, 1'b0);
        add_tri(32'd5, 32'd6, 32'd7, 16'd0, 1'b0);
        add_tri(32'd100, 32'd200, 32'd300, 16'd3, 1'b0);
        // vertex at maximum wraps the span
        add_tri(32'hFFFF_FFFF, 32'd1, 32'd2, 16'd3, 1'b0);
        add_tri(32'd65535, 32'd65535, 32'd65535, 16'hFFFF, 1'b0);
        add_tri(32'd0, 32'd0, 32'd0, 16'hFFFF, 1'b1);
        // empty leading group, largest index right at the wide limit
        add_tri(32'd40, 32'd41, 32'd42, 16'd7, 1'b0);
        add_tri(32'd65535, 32'd1, 32'd2, 16'd7, 1'b1);
        add_tri(32'd65536, 32'd3, 32'd4, 16'd0, 1'b1);
        // close and final on one triangle
        add_tri(32'd1, 32'd2, 32'd3, 16'd5, 1'b1);
        add_tri(32'hAAAA_AAAA, 32'h5555_5555, 32'h1234_5678, 16'hAAAA, 1'b0);
        add_tri(32'h5555_5555, 32'hAAAA_AAAA, 32'hEDCB_A987, 16'h5555, 1'b1);
        add_hold();
        add_tri(32'd0, 32'd0, 32'd0, 16'd0, 1'b1);
        add_tri(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b1);
        add_tri(32'd9, 32'd8, 32'd7, 16'h8000, 1'b0);
        add_tri(32'd6, 32'd5, 32'd4, 16'h0001, 1'b1);
        while (tris_total < TARGET_TRIS) begin
            len = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 40);
            add_random_mesh(len);
            if (tris_total >= TARGET_TRIS / 2 && tris_total < TARGET_TRIS / 2 + 40)
                add_hold();
        end
    endfunction

    // idle mix per phase, keyed to progress through the triangles
    always_comb begin
        if (tris_accepted < tris_total / 3) begin
            tx_idle_pct = 29;
            rx_idle_pct = 86;
        end else if (tris_accepted < (2 * tris_total) / 3) begin
            tx_idle_pct = 86;
            rx_idle_pct = 29;
        end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
        end
    end

    always @(posedge i_clk) begin
        logic      taken;
        logic      next_valid;
        t_tri_item t;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            taken = i_valid && !o_stall;
            if (taken) begin
                fold_triangle(i_vertex_a, i_vertex_b, i_vertex_c, i_material,
                              i_last_triangle);
                tris_accepted++;
            end
            next_valid = i_valid && !taken;
            if (!next_valid) begin
                if (pending_tris.size() > 0 && pending_tris[0].hold
                    && expected_groups.size() == 0)
                    void'(pending_tris.pop_front());
                if (pending_tris.size() > 0 && !pending_tris[0].hold
                    && $urandom_range(99) >= tx_idle_pct) begin
                    t = pending_tris.pop_front();
                    i_vertex_a      <= t.a;
                    i_vertex_b      <= t.b;
                    i_vertex_c      <= t.c;
                    i_material      <= t.mat;
                    i_last_triangle <= t.last;
                    next_valid      = 1'b1;
                end
            end
            i_valid <= next_valid;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_idle_pct);
    end

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%08h, got 0x%08h", name, exp_v, act_v);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        pgb_pkg::t_rec r;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_groups.size() == 0) begin
                $error("unexpected group record, group_number 0x%08h", o_group_number);
                mismatches++;
            end else begin
                r = expected_groups.pop_front();
                check_field("group_start_index", r.start_index, o_group_start_index);
                check_field("group_start_vertex", r.start_vertex, o_group_start_vertex);
                check_field("group_vertex_span", r.vertex_span, o_group_vertex_span);
                check_field("group_triangles", r.triangles, o_group_triangles);
                check_field("group_number", r.group_number, o_group_number);
                check_field("final_record", r.final_record, o_final_record);
                check_field("wide_indices", r.wide_indices, o_wide_indices);
                check_field("largest_index", r.largest_index, o_largest_index);
                check_field("index_total", r.index_total, o_index_total);
                groups_checked++;
            end
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d records outstanding", cycle_count,
                 expected_groups.size());
        $display("primitive_group_builder regression: fail");
        $finish;
    end

    initial begin
        clear_mesh_state();
        build_stimulus();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_tris.size() > 0 || i_valid || expected_groups.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d triangles in %0d meshes, %0d group records checked",
                 tris_accepted, meshes_closed, groups_checked);
        $display("idle phases: sender-light/receiver-heavy, reversed, then none");
        if (mismatches == 0 && expected_groups.size() == 0) begin
            $display("primitive_group_builder regression: pass");
        end else begin
            $display("primitive_group_builder regression: fail");
        end
        $finish;
    end

endmodule
